/* rtl/linear_queue_with_cancel_unit_macros.svh */
// Assertion macros used by the checker file of the queue unit.
`ifndef LINEAR_QUEUE_WITH_CANCEL_UNIT_MACROS_SVH
`define LINEAR_QUEUE_WITH_CANCEL_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LQC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("queue unit check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LQC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("queue unit check failed");

`endif

/* rtl/lqc_pkg.sv */
// Shared types and codes of the linear queue with cancel.
package lqc_pkg;

	localparam int FIELD_W = 32;

	localparam logic [1:0] CMD_ENQ    = 2'd0;
	localparam logic [1:0] CMD_DEQ    = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [FIELD_W-1:0] ticket_id;
	} lqc_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] head_id;
		logic               now_empty;
		logic               now_full;
	} lqc_rsp_t;

	// per-cell control from the queue controller
	typedef struct packed {
		logic write;      // load the key this cycle
		logic shift_all;  // dequeue: every cell takes its upper neighbor
		logic cancel;     // cancel in progress
		logic in_window;  // cell holds a live entry
		logic below_last; // cell sits below the newest entry
	} lqc_cell_ctl_t;

endpackage

/* rtl/lqc_cell.sv */
// One storage cell of the queue: holds an id, compares, shifts down.
module lqc_cell #(
	parameter int ID_WIDTH = 32
) (
	input  logic                  clk,
	input  lqc_pkg::lqc_cell_ctl_t ctl,
	input  logic [ID_WIDTH-1:0]   key,
	input  logic [ID_WIDTH-1:0]   next_id,
	input  logic                  hit_in,
	output logic [ID_WIDTH-1:0]   id_q,
	output logic                  hit_out
);
	import lqc_pkg::*;

	logic match;
	lqc_cell_ctl_t c;

	assign c       = ctl;
	assign match   = c.in_window && (id_q == key);
	// hit_out: this cell or one below it holds the first match
	assign hit_out = hit_in || match;

	always_ff @(posedge clk) begin
		if (c.write) begin
			id_q <= key;
		end else if (c.shift_all || (c.cancel && hit_out && c.below_last)) begin
			id_q <= next_id;
		end
	end

endmodule

/* rtl/linear_queue_with_cancel_unit.sv */
// Top level of the linear array queue of ticket ids with cancel by key.
//
//  channel | direction | handshake           | beat payload
//  --------+-----------+---------------------+------------------------------------
//  req     | in        | req_valid/req_stall | lqc_req_t: cmd, ticket_id
//  rsp     | out       | rsp_valid/rsp_stall | lqc_rsp_t: status, head_id, flags
//
// One command per cycle unless stalled: each beat is decoded, the cell row
// updates and the result is registered in the same cycle; rsp shows it next cycle.
// The search and compaction of a cancel run through the row of cells, one
// compare per cell and a hit bit passed up the row, so cancel needs no extra step.
// req_stall rises only while a result sits in the output register and rsp is
// stalled; a beat is taken in the cycle the waiting result leaves.
// arst_n clears the indices, the empty flag and the output valid; cell
// contents stay undefined until written and are never read before that.
module linear_queue_with_cancel_unit #(
	parameter int DEPTH    = 8,
	parameter int ID_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  lqc_pkg::lqc_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lqc_pkg::lqc_rsp_t rsp
);
	import lqc_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

	// Logical indices follow the array semantics (full means tail at the
	// last slot). Physically the oldest entry always sits in cell 0: a
	// dequeue shifts the whole row down, so the head is read at one place.
	logic [IDX_W-1:0] head_q, tail_q;
	logic             empty_q;
	logic [IDX_W-1:0] head_d, tail_d;
	logic             empty_d;

	logic             rsp_valid_q;
	lqc_rsp_t         rsp_q;

	logic             go;
	logic [IDX_W-1:0] phys_last;   // cell of the newest entry
	logic [IDX_W-1:0] wr_idx;      // cell an enqueue writes
	logic             enq_ok;
	logic             found;
	logic [1:0]       status_d;
	logic [ID_WIDTH-1:0] key;
	logic [ID_WIDTH-1:0] taken;

	logic [ID_WIDTH-1:0] cell_id [DEPTH];
	logic [ID_WIDTH-1:0] cell_next [DEPTH];
	logic [DEPTH:0]      hit_chain;
	lqc_cell_ctl_t       cell_ctl [DEPTH];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign go        = req_valid && !req_stall;
	assign key       = ID_WIDTH'(req.ticket_id);
	assign phys_last = tail_q - head_q;
	assign wr_idx    = empty_q ? '0 : phys_last + 1'b1;
	assign enq_ok    = go && (req.cmd == CMD_ENQ) && (empty_q || (tail_q != LAST));
	assign found     = hit_chain[DEPTH];
	assign hit_chain[0] = 1'b0;

	// row of cells; the top cell loops its own value as upper neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_top
			assign cell_next[i] = cell_id[i];
		end else begin : g_mid
			assign cell_next[i] = cell_id[i+1];
		end

		always_comb begin
			cell_ctl[i].write      = enq_ok && (wr_idx == IDX_W'(i));
			cell_ctl[i].shift_all  = go && (req.cmd == CMD_DEQ) && !empty_q;
			cell_ctl[i].cancel     = go && (req.cmd == CMD_CANCEL) && !empty_q;
			cell_ctl[i].in_window  = !empty_q && (IDX_W'(i) <= phys_last);
			cell_ctl[i].below_last = IDX_W'(i) < phys_last;
		end

		lqc_cell #(
			.ID_WIDTH(ID_WIDTH)
		) u_cell (
			.clk     (clk),
			.ctl     (cell_ctl[i]),
			.key     (key),
			.next_id (cell_next[i]),
			.hit_in  (hit_chain[i]),
			.id_q    (cell_id[i]),
			.hit_out (hit_chain[i+1])
		);
	end

	// command decode and index update
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		empty_d  = empty_q;
		status_d = ST_OK;
		taken    = '0;
		unique case (req.cmd)
			CMD_ENQ: begin
				if (empty_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b0;
				end else if (tail_q == LAST) begin
					status_d = ST_FULL;
				end else begin
					tail_d = tail_q + 1'b1;
				end
			end
			CMD_DEQ: begin
				if (empty_q) begin
					status_d = ST_EMPTY;
				end else begin
					taken = cell_id[0];
					if (head_q == tail_q) begin
						head_d  = '0;
						tail_d  = '0;
						empty_d = 1'b1;
					end else begin
						head_d = head_q + 1'b1;
					end
				end
			end
			CMD_CANCEL: begin
				if (empty_q) begin
					status_d = ST_EMPTY;
				end else if (!found) begin
					status_d = ST_MISSING;
				end else if (head_q == tail_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b1;
				end else begin
					tail_d = tail_q - 1'b1;
				end
			end
			default: begin
				// unused code: no operation, status ok
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (go) begin
				head_q      <= head_d;
				tail_q      <= tail_d;
				empty_q     <= empty_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each accepted beat
	always_ff @(posedge clk) begin
		if (go) begin
			rsp_q.status    <= status_d;
			rsp_q.head_id   <= FIELD_W'(taken);
			rsp_q.now_empty <= empty_d;
			rsp_q.now_full  <= !empty_d && (tail_d == LAST);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/lqc_checker.sv */
// Port-level checks of the queue unit and their bind to the top level.
`include "linear_queue_with_cancel_unit_macros.svh"

module lqc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input lqc_pkg::lqc_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input lqc_pkg::lqc_rsp_t rsp
);
	import lqc_pkg::*;

	// every accepted command yields a result in the next cycle
	`LQC_ASSERT_NEXT(a_accept_gives_result, req_valid && !req_stall, rsp_valid)
	// an accepted enqueue never leaves the queue empty
	`LQC_ASSERT_NEXT(a_enq_not_empty, req_valid && !req_stall && req.cmd == CMD_ENQ, !rsp.now_empty)
	// a full status comes only with the rear at the last slot
	`LQC_ASSERT_NOW(a_full_flags, rsp_valid && rsp.status == ST_FULL, rsp.now_full && !rsp.now_empty)
	// a stalled result stays up
	`LQC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind linear_queue_with_cancel_unit lqc_checker u_lqc_checker (.*);

/* verif/tb_linear_queue_with_cancel_unit.sv */
// Testbench of the linear ticket queue with cancel: directed corners, back-pressure and random traffic.
`timescale 1ns / 100ps

module tb_linear_queue_with_cancel_unit;
	import lqc_pkg::*;

	localparam int QDEPTH = 8;
	localparam int POOL   = 12;

	// unused command code, the block treats it as a no-op
	localparam logic [1:0] CMD_NOP = 2'd3;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	lqc_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	lqc_rsp_t rsp;

	linear_queue_with_cancel_unit #(
		.DEPTH   (QDEPTH),
		.ID_WIDTH(FIELD_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the queue. Updated once per accepted command beat, in
	// the order the block sees them, so each prediction is exact.
	// ------------------------------------------------------------------
	logic [FIELD_W-1:0] shadow_slot [QDEPTH];
	int                 shadow_head  = 0;
	int                 shadow_tail  = 0;
	bit                 shadow_empty = 1'b1;

	lqc_rsp_t replies_due[$];  // predicted response beats, oldest first
	int       mismatches = 0;
	int       cmd_seen[4];     // accepted beats per command code
	int       status_seen[4];  // predicted results per status code

	// knobs shared between the test tasks and the two idling processes
	bit send_idle    = 1'b0;
	bit recv_idle    = 1'b0;
	int hold_request = 0;

	logic [FIELD_W-1:0] id_pool [POOL];

	function automatic void shadow_go_empty();
		shadow_head  = 0;
		shadow_tail  = 0;
		shadow_empty = 1'b1;
	endfunction

	// Applies one command to the shadow queue, returns the response it must produce.
	function automatic lqc_rsp_t apply_ticket_cmd(input logic [1:0] op,
	                                              input logic [FIELD_W-1:0] id);
		lqc_rsp_t r;
		int       hit;
		r        = '0;
		r.status = ST_OK;
		case (op)
			CMD_ENQ: begin
				if (shadow_empty) begin
					shadow_head    = 0;
					shadow_tail    = 0;
					shadow_slot[0] = id;
					shadow_empty   = 1'b0;
				end else if (shadow_tail >= QDEPTH - 1) begin
					// linear queue: full once the tail reaches the last slot
					r.status = ST_FULL;
				end else begin
					shadow_tail++;
					shadow_slot[shadow_tail] = id;
				end
			end
			CMD_DEQ: begin
				if (shadow_empty) begin
					r.status = ST_EMPTY;
				end else begin
					r.head_id = shadow_slot[shadow_head];
					if (shadow_head >= shadow_tail)
						shadow_go_empty();
					else
						shadow_head++;
				end
			end
			CMD_CANCEL: begin
				if (shadow_empty) begin
					r.status = ST_EMPTY;
				end else begin
					hit = -1;
					for (int i = shadow_head; i <= shadow_tail; i++) begin
						if (hit < 0 && shadow_slot[i] == id)
							hit = i;
					end
					if (hit < 0) begin
						r.status = ST_MISSING;
					end else begin
						// close the gap: later entries move down one slot
						for (int i = hit; i < shadow_tail; i++)
							shadow_slot[i] = shadow_slot[i + 1];
						if (shadow_tail <= shadow_head)
							shadow_go_empty();
						else
							shadow_tail--;
					end
				end
			end
			default: ;
		endcase
		r.now_empty = shadow_empty;
		r.now_full  = !shadow_empty && shadow_tail == QDEPTH - 1;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Request side: one beat per call. valid stays high into the next
	// call unless a gap is taken, so back-to-back beats never see a
	// low/high pair of assignments in one step.
	// ------------------------------------------------------------------
	task automatic send_ticket_cmd(input logic [1:0] op, input logic [FIELD_W-1:0] id);
		lqc_req_t beat;
		int       gap;
		beat.cmd       = op;
		beat.ticket_id = id;
		req_valid <= 1'b1;
		req       <= beat;
		do
			@(posedge clk);
		while (req_stall);
		// accepted at this edge
		cmd_seen[op]++;
		replies_due.push_back(apply_ticket_cmd(op, id));
		status_seen[replies_due[$].status]++;
		gap = send_idle ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic sender_rest();
		req_valid <= 1'b0;
	endtask

	task automatic wait_replies_drained();
		while (replies_due.size() > 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Response side stall. A long hold-off is requested by a test task
	// and counted down here; otherwise random stall bursts.
	// ------------------------------------------------------------------
	int hold_left  = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			if (recv_idle)
				stall_left = pick_gap();
		end
	end

	// Response check: every beat taken is compared with the oldest prediction.
	always @(posedge clk) begin : reply_check
		lqc_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (replies_due.size() == 0) begin
				flag_mismatch($sformatf("response beat with nothing due: %p", rsp));
			end else begin
				want = replies_due.pop_front();
				if (rsp.status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
				if (rsp.head_id !== want.head_id)
					flag_mismatch($sformatf("head_id %h, want %h", rsp.head_id, want.head_id));
				if (rsp.now_empty !== want.now_empty)
					flag_mismatch($sformatf("now_empty %b, want %b",
						rsp.now_empty, want.now_empty));
				if (rsp.now_full !== want.now_full)
					flag_mismatch($sformatf("now_full %b, want %b",
						rsp.now_full, want.now_full));
			end
		end
	end

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Commands on an empty queue: dequeue and cancel report empty, no-op is ok.
	task automatic test_empty_queue();
		send_ticket_cmd(CMD_DEQ, 32'h0000_0000);
		send_ticket_cmd(CMD_CANCEL, 32'hFFFF_FFFF);
		send_ticket_cmd(CMD_NOP, 32'hFFFF_FFFF);
	endtask

	// Fill all slots with corner ids (one duplicated), then one more is refused.
	task automatic test_fill_to_full();
		logic [FIELD_W-1:0] corner [QDEPTH];
		corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
		           32'h8000_0000, 32'h0000_0001, 32'h1234_5678, 32'hAAAA_AAAA};
		for (int i = 0; i < QDEPTH; i++)
			send_ticket_cmd(CMD_ENQ, corner[i]);
		send_ticket_cmd(CMD_ENQ, 32'hDEAD_BEEF);
	endtask

	// Absent key, first of two equal keys, then the remaining copy at the tail.
	task automatic test_cancel_by_key();
		send_ticket_cmd(CMD_CANCEL, 32'hDEAD_BEEF);
		send_ticket_cmd(CMD_CANCEL, 32'hAAAA_AAAA);
		send_ticket_cmd(CMD_CANCEL, 32'hAAAA_AAAA);
	endtask

	// Refill to the last slot, free the head, and check the queue still
	// reports full; cancel at the head, drain, then cancel a lone entry.
	task automatic test_linear_full_and_drain();
		send_ticket_cmd(CMD_ENQ, 32'h0F0F_0F0F);
		send_ticket_cmd(CMD_ENQ, 32'hF0F0_F0F0);
		send_ticket_cmd(CMD_DEQ, 32'hFFFF_FFFF);
		send_ticket_cmd(CMD_ENQ, 32'h7FFF_FFFF);
		send_ticket_cmd(CMD_CANCEL, shadow_slot[shadow_head]);
		while (!shadow_empty)
			send_ticket_cmd(CMD_DEQ, $urandom());
		send_ticket_cmd(CMD_ENQ, 32'hC0DE_0001);
		send_ticket_cmd(CMD_CANCEL, 32'hC0DE_0001);
	endtask

	// ------------------------------------------------------------------
	// Random tests
	// ------------------------------------------------------------------

	// Ids come mostly from a small pool so keys repeat; cancels mostly pick a live entry so they hit.
	function automatic logic [FIELD_W-1:0] pick_ticket(input logic [1:0] op);
		int roll;
		roll = $urandom_range(0, 99);
		if (op == CMD_CANCEL && !shadow_empty && roll < 65)
			return shadow_slot[$urandom_range(shadow_tail, shadow_head)];
		if (roll < 85)
			return id_pool[$urandom_range(0, POOL - 1)];
		return $urandom();
	endfunction

	// Command mix leans on the queue state so it cycles through empty,
	// partly filled and full instead of sticking at one end.
	function automatic logic [1:0] pick_cmd();
		int roll;
		roll = $urandom_range(0, 99);
		if (shadow_empty)
			return (roll < 70) ? CMD_ENQ : (roll < 82) ? CMD_DEQ :
			       (roll < 95) ? CMD_CANCEL : CMD_NOP;
		if (shadow_tail == QDEPTH - 1)
			return (roll < 15) ? CMD_ENQ : (roll < 60) ? CMD_DEQ :
			       (roll < 96) ? CMD_CANCEL : CMD_NOP;
		return (roll < 45) ? CMD_ENQ : (roll < 70) ? CMD_DEQ :
		       (roll < 96) ? CMD_CANCEL : CMD_NOP;
	endfunction

	task automatic test_random_traffic(input int count);
		logic [1:0] op;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 19) == 0)
				id_pool[$urandom_range(0, POOL - 1)] = $urandom();
			op = pick_cmd();
			send_ticket_cmd(op, pick_ticket(op));
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps
	// offering beats back to back: the output register fills and the
	// block must stall its input. Then the sender waits for all replies.
	task automatic test_receiver_holdoff(input int count);
		logic [1:0] op;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		hold_request = 80;
		for (int n = 0; n < count; n++) begin
			op = pick_cmd();
			send_ticket_cmd(op, pick_ticket(op));
		end
		sender_rest();
		wait_replies_drained();
	endtask

	// Full rate on both sides, no gaps and no stalls.
	task automatic test_full_rate_burst(input int count);
		logic [1:0] op;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		for (int n = 0; n < count; n++) begin
			op = pick_cmd();
			send_ticket_cmd(op, pick_ticket(op));
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		int k;
		for (int i = 0; i < 4; i++) begin
			cmd_seen[i]    = 0;
			status_seen[i] = 0;
		end
		for (int i = 0; i < QDEPTH; i++)
			shadow_slot[i] = '0;
		for (int i = 0; i < POOL; i++)
			id_pool[i] = $urandom();
		id_pool[0] = 32'h0000_0000;
		id_pool[1] = 32'hFFFF_FFFF;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_fill_to_full();
		test_cancel_by_key();
		test_linear_full_and_drain();
		test_random_traffic(380);
		test_receiver_holdoff(24);
		test_full_rate_burst(40);
		test_random_traffic(360);

		// all beats sent: let the replies drain, bounded
		sender_rest();
		recv_idle = 1'b0;
		for (k = 0; k < 2000 && replies_due.size() > 0; k++)
			@(posedge clk);
		if (replies_due.size() > 0)
			flag_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
		repeat (4) @(posedge clk);

		$display("covered %0d enqueue, %0d dequeue, %0d cancel, %0d no-op beats",
			cmd_seen[CMD_ENQ], cmd_seen[CMD_DEQ], cmd_seen[CMD_CANCEL], cmd_seen[CMD_NOP]);
		$display("results: %0d ok, %0d full, %0d empty, %0d not found; %0d mismatches",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
			status_seen[ST_MISSING], mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog, far above the slowest legal run.
	initial begin
		#8_000_000;
		$display("timeout: replies still due %0d", replies_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
